[sv/ptf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptf_pkg
// Shared types and character constants for the path traversal filter.
// ----------------------------------------------------------------------------
package ptf_pkg;

   // Byte codes that the filter treats specially.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DOT   = 8'h2E;

   // Classification of the path segment seen so far.
   typedef enum logic [1:0] {
      PAT_BLANK = 2'd0,
      PAT_DOT   = 2'd1,
      PAT_DDOT  = 2'd2,
      PAT_REG   = 2'd3
   } pat_type;

   // Bytes that one accepted item asks the output side to send:
   // a number of held dots followed by the final byte.
   typedef struct packed {
      logic       emit;
      logic [1:0] dots;
      logic [7:0] char_val;
   } run_type;

endpackage

[sv/ptf_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptf_req_if / ptf_rsp_if
// Valid/ready channels carrying path bytes in and filtered bytes out.
// ----------------------------------------------------------------------------
interface ptf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;

   modport source (output valid, output in_char, input ready);
   modport sink (input valid, input in_char, output ready);
endinterface

interface ptf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last_of_run;

   modport source (output valid, output out_char, output last_of_run, input ready);
   modport sink (input valid, input out_char, input last_of_run, output ready);
endinterface

[sv/ptf_segment.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptf_segment
// Segment classifier and directory depth tracker; decodes one path byte
// into the run of bytes that must be sent for it.
// ----------------------------------------------------------------------------
module ptf_segment
   import ptf_pkg::*;
#(
   parameter int MAX_DEPTH = 1023
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_char,
   output run_type    run
);

   localparam int DEPTH_W = (MAX_DEPTH < 2) ? 1 : $clog2(MAX_DEPTH + 1);
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);

   pat_type              pattern_ff, pattern_in;
   logic [DEPTH_W-1:0]   depth_ff, depth_in;
   logic [1:0]           held_dots;

   // Dots held back so far in the current segment.
   always_comb begin
      unique case (pattern_ff)
         PAT_DOT:  held_dots = 2'd1;
         PAT_DDOT: held_dots = 2'd2;
         default:  held_dots = 2'd0;
      endcase
   end

   // Decode the byte against the current segment pattern.
   always_comb begin
      run.emit     = 1'b1;
      run.dots     = held_dots;
      run.char_val = in_char;
      pattern_in   = pattern_ff;
      depth_in     = depth_ff;
      priority if (in_char == CH_NUL) begin
         pattern_in = PAT_BLANK;
         depth_in   = '0;
      end else if (in_char == CH_SLASH) begin
         pattern_in = PAT_BLANK;
         if (pattern_ff == PAT_REG) begin
            if (depth_ff < DEPTH_MAX) begin
               depth_in = depth_ff + 1'b1;
            end
         end else if (pattern_ff == PAT_DDOT) begin
            // A climb above the root is dropped entirely.
            if (depth_ff != '0) begin
               depth_in = depth_ff - 1'b1;
            end else begin
               run.emit = 1'b0;
            end
         end
      end else if (in_char == CH_DOT) begin
         unique case (pattern_ff)
            PAT_BLANK: begin
               run.emit   = 1'b0;
               pattern_in = PAT_DOT;
            end
            PAT_DOT: begin
               run.emit   = 1'b0;
               pattern_in = PAT_DDOT;
            end
            default: begin
               pattern_in = PAT_REG;
            end
         endcase
      end else begin
         pattern_in = PAT_REG;
      end
   end

   // State advances once per accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= PAT_BLANK;
         depth_ff   <= '0;
      end else if (accept) begin
         pattern_ff <= pattern_in;
         depth_ff   <= depth_in;
      end
   end

endmodule

[sv/path_traversal_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_traversal_filter
// Streaming filter that keeps a request path from climbing above the root.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one path byte per item; a zero byte ends the path and
//   returns the filter to its start state. rsp_chan carries the filtered
//   bytes, with last_of_run set on the final byte sent for an input item.
//   An input item yields zero to three output items.
//   An accepted item is decoded in the same cycle into a run register; the
//   run register sends one byte per cycle into the output register while
//   that register is free or being drained by rsp_chan.
//   Throughput is one input per cycle when each input yields at most one
//   byte and rsp_chan does not stall; an input that releases held dots
//   holds off new input until its dots have drained through the single
//   output register. Inputs that yield nothing leave the run register empty.
//   When rsp_chan stalls, the output register holds its item and the run
//   register waits; req_chan.ready drops once the run register is occupied.
//   Synchronous reset clears the segment pattern, the depth and both valid
//   flags; items in flight are discarded.
// ----------------------------------------------------------------------------
module path_traversal_filter
   import ptf_pkg::*;
#(
   parameter int MAX_DEPTH = 1023
) (
   input  logic   clock,
   input  logic   reset,
   ptf_req_if.sink   req_chan,
   ptf_rsp_if.source rsp_chan
);

   run_type    run;
   logic       take;
   logic       advance;

   logic       run_valid_ff, run_valid_in;
   logic [1:0] dots_ff, dots_in;
   logic [7:0] char_ff, char_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_char_ff, out_char_in;
   logic       last_ff, last_in;

   ptf_segment #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_segment (
      .clock   (clock),
      .reset   (reset),
      .accept  (take),
      .in_char (req_chan.in_char),
      .run     (run)
   );

   // The run register moves a byte whenever the output register frees up.
   assign advance = run_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !run_valid_ff || (advance && (dots_ff == 2'd0));
   assign take = req_chan.valid && req_chan.ready;

   // Next values for the run and output registers.
   always_comb begin
      run_valid_in = run_valid_ff;
      dots_in      = dots_ff;
      char_in      = char_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      out_char_in  = out_char_ff;
      last_in      = last_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         if (dots_ff != 2'd0) begin
            out_char_in = CH_DOT;
            last_in     = 1'b0;
            dots_in     = dots_ff - 2'd1;
         end else begin
            out_char_in  = char_ff;
            last_in      = 1'b1;
            run_valid_in = 1'b0;
         end
      end
      if (take) begin
         run_valid_in = run.emit;
         dots_in      = run.dots;
         char_in      = run.char_val;
      end
   end

   // Control state takes the reset; payload registers just load.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_valid_ff <= run_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dots_ff     <= dots_in;
      char_ff     <= char_in;
      out_char_ff <= out_char_in;
      last_ff     <= last_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_char    = out_char_ff;
   assign rsp_chan.last_of_run = last_ff;

endmodule
